// ===== rtl/kl_pkg.sv =====
// Shared types, constants and helper functions for the keyword lexer.
// Used by every module of the block; depends on nothing.
package kl_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int LINE_WIDTH   = 16;
    localparam int FIELD_WIDTH  = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [4:0] KIND_LPAREN = 5'd0;
    localparam logic [4:0] KIND_RPAREN = 5'd1;
    localparam logic [4:0] KIND_LBRACE = 5'd2;
    localparam logic [4:0] KIND_RBRACE = 5'd3;
    localparam logic [4:0] KIND_SEMI   = 5'd4;
    localparam logic [4:0] KIND_PLUS   = 5'd5;
    localparam logic [4:0] KIND_MINUS  = 5'd6;
    localparam logic [4:0] KIND_STAR   = 5'd7;
    localparam logic [4:0] KIND_SLASH  = 5'd8;
    localparam logic [4:0] KIND_ASSIGN = 5'd9;
    localparam logic [4:0] KIND_EQ     = 5'd10;
    localparam logic [4:0] KIND_LT     = 5'd11;
    localparam logic [4:0] KIND_LE     = 5'd12;
    localparam logic [4:0] KIND_GT     = 5'd13;
    localparam logic [4:0] KIND_GE     = 5'd14;
    localparam logic [4:0] KIND_NUMBER = 5'd15;
    localparam logic [4:0] KIND_IDENT  = 5'd16;
    localparam logic [4:0] KIND_KW0    = 5'd17;
    localparam logic [4:0] KIND_EOF    = 5'd24;
    localparam logic [4:0] KIND_ERROR  = 5'd25;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam int KW_COUNT = 7;
    localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
        40'h00_006C_6574,
        40'h70_7269_6E74,
        40'h00_0000_6966,
        40'h00_656C_7365,
        40'h77_6869_6C65,
        40'h00_7472_7565,
        40'h66_616C_7365
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } item_t;

    typedef struct packed {
        logic [4:0]             token_kind;
        logic [FIELD_WIDTH-1:0] token_start;
        logic [FIELD_WIDTH-1:0] token_length;
        logic [FIELD_WIDTH-1:0] token_line;
        logic [7:0]             bad_char;
        logic                   last_in_run;
    } result_t;

    // All results caused by one input character.
    typedef struct packed {
        logic    two;
        result_t tok0;
        result_t tok1;
    } entry_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] len_sat(input logic [OFFSET_WIDTH-1:0] v);
        logic [FIELD_WIDTH-1:0] res;
        if (v > OFFSET_WIDTH'({FIELD_WIDTH{1'b1}})) begin
            res = '1;
        end
        else begin
            res = FIELD_WIDTH'(v);
        end
        return res;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [39:0] text, input logic overlong);
        logic [4:0] kind;
        kind = KIND_IDENT;
        if (!overlong) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (text == KW_TEXT[i] && kind == KIND_IDENT) begin
                    kind = KIND_KW0 + 5'(i);
                end
            end
        end
        return kind;
    endfunction

endpackage

// ===== rtl/keyword_lexer_unit.sv =====
// Top level of the keyword lexer: queue-style character input, queue-style
// token output and a start-line write port. Depends on kl_pkg, kl_front,
// kl_queue and kl_back.
//
// The lexer accepts one character (or the end marker) every cycle while the
// queue is not full, and gives at most one token per cycle. A character's
// results pass through the queue and the back end's hold register before
// they reach the output. A character that closes a pending token and also
// forms a token of its own gives two tokens, which the output gives one at a
// time; a four-group queue between the scanner and the output absorbs such
// bursts and output stalls before full rises. Writing cfg_data loads the line
// counter at once; write it only while the lexer is idle.
module keyword_lexer_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  kl_pkg::item_t    item,
    output logic             empty,
    input  logic             pop,
    output kl_pkg::result_t  result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data
);

    logic            accept;
    logic            entry_valid;
    kl_pkg::entry_t  entry;
    logic            q_valid, q_pop;
    kl_pkg::entry_t  q_data;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    kl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    kl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (entry_valid),
        .wr_data  (entry),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    kl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== rtl/kl_front.sv =====
// Front end of the keyword lexer: holds the scanner state, classifies each
// character and forms the one or two results it causes. Depends on kl_pkg.
module kl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  kl_pkg::item_t        item,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    output logic                 entry_valid,
    output kl_pkg::entry_t       entry
);

    typedef enum logic [2:0] {
        PC_NONE,
        PC_NUM,
        PC_IDENT,
        PC_EQ,
        PC_LT,
        PC_GT
    } pend_t;

    pend_t                            pend_reg, pend_next;
    logic [kl_pkg::OFFSET_WIDTH-1:0]  pos_reg, pos_next;
    logic [kl_pkg::OFFSET_WIDTH-1:0]  start_reg, start_next;
    logic [kl_pkg::LINE_WIDTH-1:0]    line_reg, line_next;
    logic [39:0]                      prefix_reg, prefix_next;
    logic                             over_reg, over_next;

    logic [7:0]                       c;
    logic [kl_pkg::OFFSET_WIDTH-1:0]  pos_adv;
    logic                             do_flush, do_gen;
    logic                             fl_valid, gen_valid, merged_valid;
    kl_pkg::result_t                  fl_tok, gen_tok, merged_tok, first_tok;

    assign c       = item.ch;
    assign pos_adv = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    always_comb
    begin
        pend_next    = pend_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        line_next    = line_reg;
        prefix_next  = prefix_reg;
        over_next    = over_reg;
        do_flush     = 1'b0;
        do_gen       = 1'b0;
        merged_valid = 1'b0;
        gen_valid    = 1'b0;

        gen_tok              = '0;
        gen_tok.token_start  = kl_pkg::FIELD_WIDTH'(pos_reg);
        gen_tok.token_length = kl_pkg::FIELD_WIDTH'(1);
        gen_tok.token_line   = kl_pkg::FIELD_WIDTH'(line_reg);
        gen_tok.last_in_run  = 1'b1;

        merged_tok              = '0;
        merged_tok.token_start  = kl_pkg::FIELD_WIDTH'(start_reg);
        merged_tok.token_length = kl_pkg::len_sat(pos_adv - start_reg);
        merged_tok.token_line   = kl_pkg::FIELD_WIDTH'(line_reg);
        merged_tok.last_in_run  = 1'b1;
        unique case (pend_reg)
            PC_LT:   merged_tok.token_kind = kl_pkg::KIND_LE;
            PC_GT:   merged_tok.token_kind = kl_pkg::KIND_GE;
            default: merged_tok.token_kind = kl_pkg::KIND_EQ;
        endcase

        if (item.end_of_source) begin
            do_flush             = 1'b1;
            gen_valid            = 1'b1;
            gen_tok.token_kind   = kl_pkg::KIND_EOF;
            gen_tok.token_length = '0;
        end
        else begin
            unique case (pend_reg) inside
                PC_EQ, PC_LT, PC_GT:
                begin
                    if (c == kl_pkg::CH_EQUAL) begin
                        merged_valid = 1'b1;
                        pos_next     = pos_adv;
                        pend_next    = PC_NONE;
                    end
                    else begin
                        do_flush = 1'b1;
                        do_gen   = 1'b1;
                    end
                end
                PC_NUM:
                begin
                    if (kl_pkg::is_digit(c)) begin
                        pos_next = pos_adv;
                    end
                    else begin
                        do_flush = 1'b1;
                        do_gen   = 1'b1;
                    end
                end
                PC_IDENT:
                begin
                    if (kl_pkg::is_digit(c) || kl_pkg::is_alpha(c)) begin
                        if (prefix_reg[39:32] != 8'h00) begin
                            over_next = 1'b1;
                        end
                        else begin
                            prefix_next = {prefix_reg[31:0], c};
                        end
                        pos_next = pos_adv;
                    end
                    else begin
                        do_flush = 1'b1;
                        do_gen   = 1'b1;
                    end
                end
                default: do_gen = 1'b1;
            endcase
        end

        if (do_flush) begin
            pend_next = PC_NONE;
        end

        if (do_gen) begin
            pos_next  = pos_adv;
            pend_next = PC_NONE;
            gen_valid = 1'b1;
            unique case (c) inside
                kl_pkg::CH_LPAREN:  gen_tok.token_kind = kl_pkg::KIND_LPAREN;
                kl_pkg::CH_RPAREN:  gen_tok.token_kind = kl_pkg::KIND_RPAREN;
                kl_pkg::CH_LBRACE:  gen_tok.token_kind = kl_pkg::KIND_LBRACE;
                kl_pkg::CH_RBRACE:  gen_tok.token_kind = kl_pkg::KIND_RBRACE;
                kl_pkg::CH_SEMI:    gen_tok.token_kind = kl_pkg::KIND_SEMI;
                kl_pkg::CH_PLUS:    gen_tok.token_kind = kl_pkg::KIND_PLUS;
                kl_pkg::CH_MINUS:   gen_tok.token_kind = kl_pkg::KIND_MINUS;
                kl_pkg::CH_STAR:    gen_tok.token_kind = kl_pkg::KIND_STAR;
                kl_pkg::CH_SLASH:   gen_tok.token_kind = kl_pkg::KIND_SLASH;
                kl_pkg::CH_EQUAL:
                begin
                    gen_valid  = 1'b0;
                    pend_next  = PC_EQ;
                    start_next = pos_reg;
                end
                kl_pkg::CH_LESS:
                begin
                    gen_valid  = 1'b0;
                    pend_next  = PC_LT;
                    start_next = pos_reg;
                end
                kl_pkg::CH_GREATER:
                begin
                    gen_valid  = 1'b0;
                    pend_next  = PC_GT;
                    start_next = pos_reg;
                end
                kl_pkg::CH_SPACE, kl_pkg::CH_CR, kl_pkg::CH_TAB:
                begin
                    gen_valid = 1'b0;
                end
                kl_pkg::CH_NEWLINE:
                begin
                    gen_valid = 1'b0;
                    line_next = (line_reg == '1) ? line_reg : line_reg + 1'b1;
                end
                default:
                begin
                    if (kl_pkg::is_digit(c)) begin
                        gen_valid  = 1'b0;
                        pend_next  = PC_NUM;
                        start_next = pos_reg;
                    end
                    else if (kl_pkg::is_alpha(c)) begin
                        gen_valid   = 1'b0;
                        pend_next   = PC_IDENT;
                        start_next  = pos_reg;
                        prefix_next = {32'h0, c};
                        over_next   = 1'b0;
                    end
                    else begin
                        gen_tok.token_kind = kl_pkg::KIND_ERROR;
                        gen_tok.bad_char   = c;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        fl_valid             = do_flush && (pend_reg != PC_NONE);
        fl_tok               = '0;
        fl_tok.token_start   = kl_pkg::FIELD_WIDTH'(start_reg);
        fl_tok.token_length  = kl_pkg::FIELD_WIDTH'(1);
        fl_tok.token_line    = kl_pkg::FIELD_WIDTH'(line_reg);
        fl_tok.last_in_run   = !gen_valid;
        unique case (pend_reg)
            PC_NUM:
            begin
                fl_tok.token_kind   = kl_pkg::KIND_NUMBER;
                fl_tok.token_length = kl_pkg::len_sat(pos_reg - start_reg);
            end
            PC_IDENT:
            begin
                fl_tok.token_kind   = kl_pkg::ident_kind(prefix_reg, over_reg);
                fl_tok.token_length = kl_pkg::len_sat(pos_reg - start_reg);
            end
            PC_LT:   fl_tok.token_kind = kl_pkg::KIND_LT;
            PC_GT:   fl_tok.token_kind = kl_pkg::KIND_GT;
            default: fl_tok.token_kind = kl_pkg::KIND_ASSIGN;
        endcase

        if (merged_valid) begin
            first_tok = merged_tok;
        end
        else if (fl_valid) begin
            first_tok = fl_tok;
        end
        else begin
            first_tok = gen_tok;
        end

        entry_valid = accept && (merged_valid || fl_valid || gen_valid);
        entry.two   = fl_valid && gen_valid;
        entry.tok0  = first_tok;
        entry.tok1  = gen_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg   <= PC_NONE;
            pos_reg    <= '0;
            start_reg  <= '0;
            line_reg   <= kl_pkg::LINE_WIDTH'(1);
            prefix_reg <= '0;
            over_reg   <= 1'b0;
        end
        else if (cfg_we) begin
            line_reg <= kl_pkg::LINE_WIDTH'(cfg_data);
        end
        else if (accept) begin
            pend_reg   <= pend_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            over_reg   <= over_next;
        end
    end

`ifndef SYNTH
    // The end marker, when taken without a start-line write, leaves nothing pending.
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.end_of_source && !cfg_we) |=> (pend_reg == PC_NONE))
        else $error("pending token survived end marker");

    // A pair of results is only ever a flushed token followed by a fresh one.
    a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_valid && entry.two) |-> (!entry.tok0.last_in_run && entry.tok1.last_in_run))
        else $error("bad last marker in result pair");
`endif

endmodule

// ===== rtl/kl_queue.sv =====
// Short queue of result groups between the lexer front and back ends.
// Depends on kl_pkg for the entry type and depth.
module kl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  kl_pkg::entry_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output kl_pkg::entry_t  rd_data
);

    kl_pkg::entry_t           mem [kl_pkg::Q_DEPTH];
    logic [kl_pkg::Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [kl_pkg::Q_AW:0]    count_reg, count_next;

    assign full     = (count_reg == (kl_pkg::Q_AW+1)'(kl_pkg::Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !(rd_en && rd_valid)) begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en && rd_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == kl_pkg::Q_AW'(kl_pkg::Q_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en && rd_valid) begin
                rd_ptr_reg <= (rd_ptr_reg == kl_pkg::Q_AW'(kl_pkg::Q_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("request written into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (kl_pkg::Q_AW+1)'(kl_pkg::Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== rtl/kl_back.sv =====
// Back end of the keyword lexer: takes result groups from the queue and
// presents their results one at a time to the output. Depends on kl_pkg.
module kl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  kl_pkg::entry_t   q_data,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output kl_pkg::result_t  result
);

    logic            hold_valid_reg;
    kl_pkg::entry_t  hold_reg;
    logic            sel_reg;
    logic            taken, consume, load;

    assign empty   = !hold_valid_reg;
    assign result  = sel_reg ? hold_reg.tok1 : hold_reg.tok0;
    assign taken   = pop && hold_valid_reg;
    assign consume = taken && (sel_reg || !hold_reg.two);
    assign load    = q_valid && (!hold_valid_reg || consume);
    assign q_pop   = load;

    always_ff @(posedge clk)
    begin
        if (load) begin
            hold_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            sel_reg        <= 1'b0;
        end
        else if (load) begin
            hold_valid_reg <= 1'b1;
            sel_reg        <= 1'b0;
        end
        else if (consume) begin
            hold_valid_reg <= 1'b0;
            sel_reg        <= 1'b0;
        end
        else if (taken) begin
            sel_reg <= 1'b1;
        end
    end

`ifndef SYNTH
    a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (hold_valid_reg && hold_reg.two))
        else $error("second result selected from a single-result group");
`endif

endmodule
